>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MMEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MMEP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mmep_pkg.sv
// Package for the min/max envelope pyramid: payload types, defaults, register indexes.
`timescale 1ns / 1ps
package mmep_pkg;

  localparam int LEVELS_DEF      = 3;
  localparam int WINDOW_LOG2_DEF = 8;
  localparam int MAX_LEVELS      = 8;
  localparam int NRES_W          = $clog2(MAX_LEVELS + 1);
  localparam int IDX_W           = 24;

  localparam logic [0:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [0:0] REG_RANGE_HIGH = 1'b1;

  localparam logic [7:0] RANGE_LOW_RST  = 8'd0;
  localparam logic [7:0] RANGE_HIGH_RST = 8'd255;
  localparam logic [7:0] MIN_RST        = 8'hFF;
  localparam logic [7:0] MAX_RST        = 8'h00;

  typedef struct packed {
    logic [7:0] sample;
    logic       restart;
    logic       payload_start;
  } in_item_t;

  typedef struct packed {
    logic             entry_valid;
    logic [2:0]       level;
    logic [7:0]       env_min;
    logic [7:0]       env_max;
    logic [IDX_W-1:0] entry_index;
    logic             out_of_range;
    logic             last;
  } out_item_t;

  // One finished envelope entry
  typedef struct packed {
    logic [7:0]       env_min;
    logic [7:0]       env_max;
    logic [IDX_W-1:0] idx;
  } entry_t;

  // Control part of a request walking down the cell chain
  typedef struct packed {
    logic              restart;
    logic              oor;
    logic              carry;
    logic [7:0]        cmin;
    logic [7:0]        cmax;
    logic [NRES_W-1:0] nres;
  } tok_ctl_t;

endpackage

>>> rtl/min_max_envelope_pyramid.sv
// A request is held in the request register of each level's cell in turn, then in the
// output stage, before its first result is offered. Throughput: one sample per cycle
// through a cell per level while not stalled; a sample that closes k windows holds the
// output stage for k results; back-to-back input then stalls once the cells are full.
// Reset: synchronous, active low; clears every window, fill, entry index and the out-of-range
// flag, and returns the range registers to their defaults at once, with no clearing pass.
`timescale 1ns / 1ps
module min_max_envelope_pyramid #(
  parameter int LEVELS      = mmep_pkg::LEVELS_DEF,
  parameter int WINDOW_LOG2 = mmep_pkg::WINDOW_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmep_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mmep_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0] range_low_r, range_high_r;
  logic       flag_r, flag_nxt;
  logic       in_acc;

  mmep_pkg::tok_ctl_t            ctl_in;
  logic                          v   [LEVELS+1];
  logic                          rdy [LEVELS+1];
  mmep_pkg::tok_ctl_t            ctl [LEVELS+1];
  mmep_pkg::entry_t [LEVELS-1:0] ent [LEVELS+1];

  assign in_stall = !rdy[0];
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    flag_nxt = in_data.payload_start ? 1'b0 : flag_r;
    if ((in_data.sample > range_high_r) || (in_data.sample < range_low_r)) begin
      flag_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= mmep_pkg::RANGE_LOW_RST;
      range_high_r <= mmep_pkg::RANGE_HIGH_RST;
      flag_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == mmep_pkg::REG_RANGE_LOW) begin
          range_low_r <= cfg_wdata;
        end else begin
          range_high_r <= cfg_wdata;
        end
      end
      if (in_acc) begin
        flag_r <= flag_nxt;
      end
    end
  end

  // the sample enters level 0 as a one-value window
  always_comb begin
    ctl_in.restart = in_data.restart;
    ctl_in.oor     = flag_nxt;
    ctl_in.carry   = 1'b1;
    ctl_in.cmin    = in_data.sample;
    ctl_in.cmax    = in_data.sample;
    ctl_in.nres    = '0;
  end
  assign ctl[0] = ctl_in;
  assign v[0]   = in_valid;
  assign ent[0] = '0;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    mmep_cell #(
      .LEVELS      (LEVELS),
      .WINDOW_LOG2 (WINDOW_LOG2),
      .LEVEL_IDX   (l)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (v[l]),
      .ctl_i   (ctl[l]),
      .ent_i   (ent[l]),
      .ready_o (rdy[l]),
      .valid_o (v[l+1]),
      .ctl_o   (ctl[l+1]),
      .ent_o   (ent[l+1]),
      .ready_i (rdy[l+1])
    );
  end

  mmep_emit #(
    .LEVELS (LEVELS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (v[LEVELS]),
    .ctl_i     (ctl[LEVELS]),
    .ent_i     (ent[LEVELS]),
    .ready_o   (rdy[LEVELS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/mmep_cell.sv
// One envelope level: window min/max, fill and entry index, plus the request register to the next level.
`timescale 1ns / 1ps
module mmep_cell #(
  parameter int LEVELS      = mmep_pkg::LEVELS_DEF,
  parameter int WINDOW_LOG2 = mmep_pkg::WINDOW_LOG2_DEF,
  parameter int LEVEL_IDX   = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_i,
  input  mmep_pkg::tok_ctl_t                ctl_i,
  input  mmep_pkg::entry_t [LEVELS-1:0]     ent_i,
  output logic                              ready_o,
  output logic                              valid_o,
  output mmep_pkg::tok_ctl_t                ctl_o,
  output mmep_pkg::entry_t [LEVELS-1:0]     ent_o,
  input  logic                              ready_i
);

  logic [7:0]                 wmin_r, wmin_nxt;
  logic [7:0]                 wmax_r, wmax_nxt;
  logic [WINDOW_LOG2-1:0]     fill_r, fill_nxt;
  logic [mmep_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic                       valid_r;
  mmep_pkg::tok_ctl_t         ctl_r, ctl_nxt;
  mmep_pkg::entry_t [LEVELS-1:0] ent_r, ent_nxt;

  logic [7:0]                 base_min, base_max, new_min, new_max;
  logic [WINDOW_LOG2-1:0]     base_fill;
  logic [mmep_pkg::IDX_W-1:0] base_cnt;
  logic                       done, take;

  assign ready_o = !valid_r || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    // restart clears the window before this request touches it
    base_min  = ctl_i.restart ? mmep_pkg::MIN_RST : wmin_r;
    base_max  = ctl_i.restart ? mmep_pkg::MAX_RST : wmax_r;
    base_fill = ctl_i.restart ? '0 : fill_r;
    base_cnt  = ctl_i.restart ? '0 : cnt_r;
    new_min   = (ctl_i.cmin < base_min) ? ctl_i.cmin : base_min;
    new_max   = (ctl_i.cmax > base_max) ? ctl_i.cmax : base_max;
    done      = ctl_i.carry && (&base_fill);

    wmin_nxt = base_min;
    wmax_nxt = base_max;
    fill_nxt = base_fill;
    cnt_nxt  = base_cnt;
    if (done) begin
      wmin_nxt = mmep_pkg::MIN_RST;
      wmax_nxt = mmep_pkg::MAX_RST;
      fill_nxt = '0;
      cnt_nxt  = base_cnt + mmep_pkg::IDX_W'(1);
    end else if (ctl_i.carry) begin
      wmin_nxt = new_min;
      wmax_nxt = new_max;
      fill_nxt = base_fill + WINDOW_LOG2'(1);
    end

    ctl_nxt       = ctl_i;
    ctl_nxt.carry = done;
    ctl_nxt.cmin  = new_min;
    ctl_nxt.cmax  = new_max;
    ent_nxt       = ent_i;
    if (done) begin
      ctl_nxt.nres               = mmep_pkg::NRES_W'(LEVEL_IDX + 1);
      ent_nxt[LEVEL_IDX].env_min = new_min;
      ent_nxt[LEVEL_IDX].env_max = new_max;
      ent_nxt[LEVEL_IDX].idx     = base_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wmin_r  <= mmep_pkg::MIN_RST;
      wmax_r  <= mmep_pkg::MAX_RST;
      fill_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (ready_o) begin
        valid_r <= valid_i;
      end
      if (take) begin
        wmin_r <= wmin_nxt;
        wmax_r <= wmax_nxt;
        fill_r <= fill_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r <= ctl_nxt;
      ent_r <= ent_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign ent_o   = ent_r;

endmodule

>>> rtl/mmep_emit.sv
// Output stage: holds a done request, hands out its entries one per cycle unless stalled.
`timescale 1ns / 1ps
module mmep_emit #(
  parameter int LEVELS = mmep_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  mmep_pkg::tok_ctl_t            ctl_i,
  input  mmep_pkg::entry_t [LEVELS-1:0] ent_i,
  output logic                          ready_o,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mmep_pkg::out_item_t           out_data
);

  localparam int PW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic                          busy_r;
  logic [PW-1:0]                 pos_r;
  logic [mmep_pkg::NRES_W-1:0]   nres_r;
  logic                          oor_r;
  mmep_pkg::entry_t [LEVELS-1:0] ent_r;
  mmep_pkg::entry_t              cur;
  logic                          has_ent, is_last, acc, load;

  assign has_ent = (nres_r != '0);
  assign is_last = !has_ent || (mmep_pkg::NRES_W'(pos_r) == nres_r - mmep_pkg::NRES_W'(1));
  assign acc     = busy_r && !out_stall;
  assign ready_o = !busy_r || (acc && is_last);
  assign load    = valid_i && ready_o;
  assign cur     = ent_r[pos_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (acc) begin
      // advance to the next level, or drop the request after its last entry
      busy_r <= !is_last;
      pos_r  <= is_last ? '0 : pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nres_r <= ctl_i.nres;
      oor_r  <= ctl_i.oor;
      ent_r  <= ent_i;
    end
  end

  always_comb begin
    out_data              = '0;
    out_data.entry_valid  = has_ent;
    out_data.out_of_range = oor_r;
    out_data.last         = is_last;
    if (has_ent) begin
      out_data.level       = 3'(pos_r);
      out_data.env_min     = cur.env_min;
      out_data.env_max     = cur.env_max;
      out_data.entry_index = cur.idx;
    end
  end

  assign out_valid = busy_r;

endmodule

>>> rtl/mmep_checker.sv
// Port-level checks for the envelope pyramid and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mmep_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input mmep_pkg::out_item_t out_data
);

  logic       mid_acc, ent_ok, empty_ok, oor;
  logic [2:0] lvl_inc;

  // a result that is taken and is not the last of its request
  assign mid_acc  = out_valid && !out_stall && !out_data.last;
  assign ent_ok   = out_valid && out_data.entry_valid;
  assign empty_ok = out_data.last && (out_data.level == 3'd0) && (out_data.env_min == 8'd0)
                    && (out_data.env_max == 8'd0) && (out_data.entry_index == '0);
  assign oor      = out_data.out_of_range;
  assign lvl_inc  = out_data.level + 3'd1;

  `MMEP_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "output valid right after reset")
  `MMEP_ASSERT(a_empty_last, out_valid && !out_data.entry_valid |-> empty_ok, "empty result bad")
  `MMEP_ASSERT(a_min_le_max, ent_ok |-> out_data.env_min <= out_data.env_max, "min above max")
  `MMEP_ASSERT(a_next_level, mid_acc |=> ent_ok && out_data.level == $past(lvl_inc), "burst broken")
  `MMEP_ASSERT(a_oor_hold, mid_acc |=> oor == $past(oor), "flag changed within one request")

endmodule

bind min_max_envelope_pyramid mmep_checker u_mmep_checker (.*);
